@@ sv/signed_int_to_decimal_ascii_unit_macros.svh @@
// Assertion macros shared by the decimal text converter modules.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define SITDA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define SITDA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ sv/sitda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants, types and helpers of the signed integer to decimal text
// converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

    // Default input width
    localparam int VALUE_WIDTH_DEF = 32;

    // ASCII codes
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // BCD correction of the shift-and-add-3 conversion
    localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJ       = 4'd3;

    // Decimal digits needed for a magnitude up to 2^(w-1); 30103 ~ 1e5*log10(2)
    function automatic int dec_digits(input int w);
        return ((w - 1) * 30103) / 100000 + 1;
    endfunction

    // Status returned by the converter to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } conv_status_t;

endpackage

@@ sv/signed_int_to_decimal_ascii_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a signed integer to its decimal ASCII text, one byte per transfer.
// ----------------------------------------------------------------------------
// One value is taken at a time. After a value transfer, the magnitude is
// converted to BCD bit-serially (one cycle per input bit through the
// shift-and-add-3 converter), leading zero digits are then dropped at one
// cycle per digit, and the text goes out one byte per cycle while the
// receiver accepts: an optional '-' followed by the digits, most significant
// first, with m_last_char set on the final digit. The next value is taken
// while the final byte still waits in the output register. The most
// negative value prints as its full magnitude, e.g. "-2147483648".
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module signed_int_to_decimal_ascii_unit #(
    parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_char_byte,
    output logic                          m_last_char
);
    import sitda_pkg::*;

    localparam int NUM_DIGITS = dec_digits(VALUE_WIDTH);
    localparam int DIG_W      = NUM_DIGITS * 4;
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [DIG_W-1:0]       dig_reg, dig_next;
    logic [LEFT_W-1:0]      left_reg, left_next;
    logic                   sign_pend_reg, sign_pend_next;
    logic                   m_valid_reg, m_valid_next;
    logic [7:0]             m_char_reg, m_char_next;
    logic                   m_last_reg, m_last_next;

    logic                   in_xfer;
    logic                   out_load;
    logic [VALUE_WIDTH-1:0] mag;
    logic [3:0]             top_digit;
    conv_status_t           conv_status;
    logic [DIG_W-1:0]       conv_bcd;

    assign in_xfer   = s_valid && s_ready;
    assign out_load  = !m_valid_reg || m_ready;
    assign top_digit = dig_reg[DIG_W-1 -: 4];

    // Take the magnitude; the most negative value wraps to 2^(W-1) unsigned
    assign mag = s_value[VALUE_WIDTH-1] ? (~s_value + VALUE_WIDTH'(1)) : s_value;

    sitda_bcd_conv #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_xfer),
        .mag     (mag),
        .status  (conv_status),
        .bcd     (conv_bcd)
    );

    // Sequence conversion, zero skipping and byte output
    always_comb begin
        state_next     = state_reg;
        dig_next       = dig_reg;
        left_next      = left_reg;
        sign_pend_next = sign_pend_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_char_next    = m_char_reg;
        m_last_next    = m_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    sign_pend_next = s_value[VALUE_WIDTH-1];
                    state_next     = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_status.done) begin
                    dig_next   = conv_bcd;
                    left_next  = LEFT_W'(NUM_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zeros, keeping at least one digit
                if ((top_digit == 4'd0) && (left_reg > LEFT_W'(1))) begin
                    dig_next  = {dig_reg[DIG_W-5:0], 4'd0};
                    left_next = left_reg - LEFT_W'(1);
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    if (sign_pend_reg) begin
                        m_char_next    = CHAR_MINUS;
                        m_last_next    = 1'b0;
                        sign_pend_next = 1'b0;
                    end else begin
                        m_char_next = CHAR_ZERO + {4'd0, top_digit};
                        m_last_next = (left_reg == LEFT_W'(1));
                        dig_next    = {dig_reg[DIG_W-5:0], 4'd0};
                        left_next   = left_reg - LEFT_W'(1);
                        if (left_reg == LEFT_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        dig_reg    <= dig_next;
        left_reg   <= left_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sign_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sign_pend_reg <= sign_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_char_byte = m_char_reg;
    assign m_last_char = m_last_reg;

    `SITDA_ASSERT_SAME(a_minus_not_last, aclk, aresetn, m_valid_reg && (m_char_reg == CHAR_MINUS), !m_last_reg)
    `SITDA_ASSERT_SAME(a_emit_has_digits, aclk, aresetn, (state_reg == ST_EMIT) || (state_reg == ST_SKIP), left_reg != '0)
    `SITDA_ASSERT_SAME(a_take_when_free, aclk, aresetn, in_xfer, !conv_status.busy)

endmodule

@@ sv/sitda_bcd_conv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_bcd_conv
// Bit-serial binary to BCD converter: shifts the magnitude in one bit per
// cycle, MSB first, adding 3 to each BCD digit of 5 or more before a shift.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module sitda_bcd_conv #(
    parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF,
    parameter int NUM_DIGITS  = sitda_pkg::dec_digits(sitda_pkg::VALUE_WIDTH_DEF)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [VALUE_WIDTH-1:0]      mag,
    output sitda_pkg::conv_status_t     status,
    output logic [NUM_DIGITS*4-1:0]     bcd
);
    import sitda_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int BCD_W = NUM_DIGITS * 4;

    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    // Add 3 to every digit of 5 or more
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] >= BCD_ADJ_LIMIT) begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + BCD_ADJ;
            end else begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    // Load, then shift one magnitude bit per cycle
    always_comb begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            mag_next  = mag;
            bcd_next  = '0;
            cnt_next  = CNT_W'(VALUE_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign bcd         = bcd_reg;

    `SITDA_ASSERT_SAME(a_start_idle, aclk, aresetn, start, !busy_reg)
    `SITDA_ASSERT_NEXT(a_last_shift_done, aclk, aresetn, busy_reg && !start && (cnt_reg == CNT_W'(1)), done_reg)
    `SITDA_ASSERT_SAME(a_done_not_busy, aclk, aresetn, done_reg, !busy_reg)

endmodule

@@ tb/signed_int_to_decimal_ascii_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_tb
// Self-checking bench for the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
// Values go in through the s_ channel; every m_ channel byte is compared with
// the text typed in the table, else an in-bench decimal formatter's text for
// the accepted value. The table covers zero, single and multi-digit values,
// both extremes and sign changes; random values of every digit count follow.
// Both sides idle and stall at random in several phases, and one phase holds
// the receiver off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit_tb;

    localparam int VW            = sitda_pkg::VALUE_WIDTH_DEF;
    localparam int DIRECTED_N    = 20;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_char;
    } text_char_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic signed [VW-1:0] s_value     = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [7:0]           m_char_byte;
    logic                 m_last_char;

    // Text still owed by the block, oldest byte first
    text_char_t expected_chars[$];
    text_char_t want;

    int error_count    = 0;
    int values_sent    = 0;
    int negatives_sent = 0;
    int chars_checked  = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int hold_requests  = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    // Directed values; a non-empty text is the expected output typed in
    logic [VW-1:0] directed_value [DIRECTED_N] = '{
        32'd0,          32'd1,          -32'sd1,        32'd9,
        32'd10,         -32'sd10,       32'h7FFF_FFFF,  32'h8000_0000,
        32'h8000_0001,  32'd99,         32'd100,        -32'sd99,
        32'd999999999,  32'd1000000000, -32'sd1000000000, 32'h5555_5555,
        32'hAAAA_AAAA,  32'd12345,      -32'sd123456789, 32'h7FFF_FFFE
    };
    string directed_text [DIRECTED_N] = '{
        "0",          "1",           "-1",          "9",
        "10",         "-10",         "2147483647",  "-2147483648",
        "-2147483647", "",           "",            "",
        "",           "",            "",            "",
        "",           "",            "",            ""
    };

    signed_int_to_decimal_ascii_unit #(
        .VALUE_WIDTH(VW)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_char_byte(m_char_byte),
        .m_last_char(m_last_char)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Queue the decimal text of one value: sign, then digits MSB first
    task automatic queue_decimal_text(input logic [VW-1:0] v);
        logic [VW-1:0] mag;
        logic [7:0]    digits[$];
        text_char_t    c;
        mag = v[VW-1] ? (~v + 1'b1) : v;
        do begin
            digits.push_front(8'(mag % 10) + sitda_pkg::CHAR_ZERO);
            mag = mag / 10;
        end while (mag != 0);
        if (v[VW-1]) begin
            c.char_byte = sitda_pkg::CHAR_MINUS;
            c.last_char = 1'b0;
            expected_chars.push_back(c);
        end
        foreach (digits[i]) begin
            c.char_byte = digits[i];
            c.last_char = (i == digits.size() - 1);
            expected_chars.push_back(c);
        end
    endtask

    // Queue text copied straight from the directed table
    task automatic queue_typed_text(input string s);
        text_char_t c;
        for (int i = 0; i < s.len(); i++) begin
            c.char_byte = s[i];
            c.last_char = (i == s.len() - 1);
            expected_chars.push_back(c);
        end
    endtask

    // Offer one value, with random gaps first; return at the next falling edge
    task automatic send_value(input logic [VW-1:0] v, input string typed);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        if (typed.len() != 0) queue_typed_text(typed);
        else queue_decimal_text(v);
        values_sent++;
        if (v[VW-1]) negatives_sent++;
        @(negedge aclk);
    endtask

    // Drop valid and wait until all owed text is out and the block settles
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Random value, spread over every digit count and both signs
    function automatic logic [VW-1:0] pick_value();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mag;
        int          ndig;
        logic        neg;
        neg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0, 1: return VW'($urandom);
            2: begin
                ndig = $urandom_range(1, 10);
                lo = 64'd1;
                for (int i = 1; i < ndig; i++) lo = lo * 10;
                hi = lo * 10 - 1;
                if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
                mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
            end
            3: begin
                mag = 64'd1;
                for (int i = $urandom_range(0, 9); i > 0; i--) mag = mag * 10;
                mag = mag + $urandom_range(0, 2) - 1;
            end
            4: mag = 64'($urandom_range(0, 20));
            default: begin
                return neg ? (32'h8000_0000 + $urandom_range(0, 3))
                           : (32'h7FFF_FFFF - $urandom_range(0, 3));
            end
        endcase
        return neg ? VW'(-mag) : VW'(mag);
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_value(pick_value(), "");
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Compare each output transfer with the oldest owed byte
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected byte 0x%02h last=%0b", m_char_byte, m_last_char);
            end else begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (m_char_byte !== want.char_byte) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("char_byte mismatch: expected 0x%02h got 0x%02h",
                                 want.char_byte, m_char_byte);
                end
                if (m_last_char !== want.last_char) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("last_char mismatch on 0x%02h: expected %0b got %0b",
                                 want.char_byte, want.last_char, m_last_char);
                end
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d cycles without a transfer", idle_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table, no idling
        for (int i = 0; i < DIRECTED_N; i++)
            send_value(directed_value[i], directed_text[i]);
        settle();

        send_random(50);
        settle();

        // Hold the receiver off while values keep coming
        hold_requests++;
        send_random(14);
        settle();

        send_idle_pct = 69;
        send_random(65);
        settle();

        send_idle_pct = 0;
        stall_pct     = 69;
        send_random(65);
        settle();

        send_idle_pct = 6;
        stall_pct     = 6;
        send_random(65);
        settle();

        $display("converted %0d values (%0d negative), checked %0d output bytes",
                 values_sent, negatives_sent, chars_checked);
        $display("phases: free flow, receiver hold-off, sender gaps, receiver stalls, mixed");
        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d bytes never arrived",
                     error_count, expected_chars.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
